// ===== hw/rtl/sba_pkg.sv =====
// Shared types, register indexes and state codes of the sensor batch averager.
package sba_pkg;

    localparam int unsigned NCHAN  = 7;
    localparam int unsigned DATA_W = 16;
    localparam int unsigned TIME_W = 48;
    localparam int unsigned CFG_W  = 16;

    localparam logic [1:0] CFG_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_BATCH    = 2'd1;
    localparam logic [1:0] CFG_AVERAGE  = 2'd2;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] temp_raw;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic               read_ok;
        logic [47:0]        sample_time;
        logic [47:0]        check_time;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] out_accel_x;
        logic signed [15:0] out_accel_y;
        logic signed [15:0] out_accel_z;
        logic signed [15:0] out_temp;
        logic signed [15:0] out_gyro_x;
        logic signed [15:0] out_gyro_y;
        logic signed [15:0] out_gyro_z;
        logic [47:0]        out_time;
        logic [6:0]         batch_count;
        logic               last;
    } result_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_AVG_OUT,
        BK_PASS_RD,
        BK_PASS_OUT
    } back_state_t;

endpackage

// ===== hw/rtl/sba_if.sv =====
// Valid/ready channel interfaces for samples and results.
interface sba_sample_if;
    import sba_pkg::*;
    logic    valid;
    logic    ready;
    sample_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sba_result_if;
    import sba_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sensor_batch_averager.sv =====
// Top level of the sensor batch averager.
// Samples arrive on the samples channel and results leave on the results
// channel; both use valid/ready and a transfer happens when both are high.
// Registers are to be written through cfg_we, cfg_index and cfg_data only
// while idle; the block itself does not enforce this. Each sample is taken
// by the front end, which updates the running sums, the sample count and
// the deadline, and hands a finished batch to a two-entry job queue. In
// average mode the back end divides the seven sums serially, one quotient
// bit a cycle, while the front end keeps taking samples. In pass mode the
// stored samples are read one at a time from the sample memory into a read
// register and then loaded into the output register, and the front end
// takes no sample until the last result has been loaded.
// A stalled receiver holds the output register; the back end then waits and
// the queue fills, after which the samples channel is held off as well.
// Reset clears the count, the sums, the deadline, the queue and the output;
// the sample memory needs no clearing, as only entries of the current batch
// are read.
module sensor_batch_averager #(
    parameter int unsigned MAX_BATCH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    sba_sample_if.sink               samples,
    sba_result_if.source             results,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [sba_pkg::CFG_W-1:0] cfg_data
);
    import sba_pkg::*;

    localparam int unsigned CNT_W  = $clog2(MAX_BATCH + 1);
    localparam int unsigned ADDR_W = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int unsigned SUM_W  = DATA_W + $clog2(MAX_BATCH);
    localparam int unsigned ROW_W  = NCHAN * DATA_W + TIME_W;
    localparam int unsigned JOB_W  = 1 + CNT_W + NCHAN * SUM_W + TIME_W;

    logic [15:0]       interval_reg;
    logic [6:0]        batch_reg;
    logic              average_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ROW_W-1:0]  wr_row;
    logic              job_push, job_pop, job_full, job_empty, pass_done;
    logic [JOB_W-1:0]  job_in, job_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= 16'd10;
            batch_reg    <= 7'd10;
            average_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INTERVAL: interval_reg <= cfg_data;
                CFG_BATCH:    batch_reg    <= cfg_data[6:0];
                CFG_AVERAGE:  average_reg  <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    sba_front #(
        .MAX_BATCH (MAX_BATCH),
        .CNT_W     (CNT_W),
        .ADDR_W    (ADDR_W),
        .SUM_W     (SUM_W),
        .ROW_W     (ROW_W),
        .JOB_W     (JOB_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .samples        (samples),
        .interval_ms    (interval_reg),
        .batch_size     (batch_reg),
        .average_enable (average_reg),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_row         (wr_row),
        .job_push       (job_push),
        .job_data       (job_in),
        .job_full       (job_full),
        .pass_done      (pass_done)
    );

    sba_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .pop_data  (job_out),
        .full      (job_full),
        .empty     (job_empty)
    );

    sba_back #(
        .MAX_BATCH (MAX_BATCH),
        .CNT_W     (CNT_W),
        .ADDR_W    (ADDR_W),
        .SUM_W     (SUM_W),
        .ROW_W     (ROW_W),
        .JOB_W     (JOB_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_row    (wr_row),
        .job_data  (job_out),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .pass_done (pass_done),
        .results   (results)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(job_push && job_full))
        else $error("job pushed into a full queue");

    a_pass_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        pass_done |=> results.valid && results.data.last)
        else $error("end of pass batch without a last result");

    a_not_last_multi: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.data.last) |-> (results.data.batch_count > 7'd1))
        else $error("non-final result in a batch of one");

endmodule

// ===== hw/rtl/sba_front.sv =====
// Front end: accepts samples, keeps running sums, count and deadline, and issues batch jobs.
module sba_front #(
    parameter int unsigned MAX_BATCH = 64,
    parameter int unsigned CNT_W     = 7,
    parameter int unsigned ADDR_W    = 6,
    parameter int unsigned SUM_W     = 22,
    parameter int unsigned ROW_W     = 160,
    parameter int unsigned JOB_W     = 209
) (
    input  logic                    clk,
    input  logic                    rst_n,
    sba_sample_if.sink              samples,
    input  logic [15:0]             interval_ms,
    input  logic [6:0]              batch_size,
    input  logic                    average_enable,
    output logic                    wr_en,
    output logic [ADDR_W-1:0]       wr_addr,
    output logic [ROW_W-1:0]        wr_row,
    output logic                    job_push,
    output logic [JOB_W-1:0]        job_data,
    input  logic                    job_full,
    input  logic                    pass_done
);
    import sba_pkg::*;

    logic signed [SUM_W-1:0] sums_reg [NCHAN];
    logic signed [SUM_W-1:0] sums_next [NCHAN];
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [47:0]             deadline_reg, deadline_next;
    logic                    armed_reg;
    logic                    wait_reg, wait_next;
    logic signed [15:0]      ch [NCHAN];
    logic [CNT_W-1:0]        size_eff;
    logic [47:0]             dl_cur;
    logic [15+CNT_W:0]       advance;
    logic                    accept, emit;

    assign ch[0] = samples.data.accel_x;
    assign ch[1] = samples.data.accel_y;
    assign ch[2] = samples.data.accel_z;
    assign ch[3] = samples.data.temp_raw;
    assign ch[4] = samples.data.gyro_x;
    assign ch[5] = samples.data.gyro_y;
    assign ch[6] = samples.data.gyro_z;

    assign samples.ready = !job_full && !wait_reg;
    assign accept        = samples.valid && samples.ready;

    always_comb
    begin
        if (batch_size == 7'd0)
        begin
            size_eff = CNT_W'(1);
        end
        else if (batch_size > 7'(MAX_BATCH))
        begin
            size_eff = CNT_W'(MAX_BATCH);
        end
        else
        begin
            size_eff = batch_size[CNT_W-1:0];
        end
    end

    assign dl_cur  = armed_reg ? deadline_reg : samples.data.sample_time;
    assign advance = interval_ms * size_eff;

    always_comb
    begin
        for (int c = 0; c < NCHAN; c++)
        begin
            sums_next[c] = samples.data.read_ok ? sums_reg[c] + SUM_W'(ch[c]) : '0;
        end
        count_next = samples.data.read_ok ? count_reg + CNT_W'(1) : '0;
        emit = (count_next >= size_eff) || (samples.data.check_time > dl_cur);
        deadline_next = emit ? dl_cur + 48'(advance) : dl_cur;
        job_push = accept && emit && (count_next != '0);
        wait_next = wait_reg;
        if (pass_done)
        begin
            wait_next = 1'b0;
        end
        if (job_push && !average_enable)
        begin
            wait_next = 1'b1;
        end
        job_data = '0;
        job_data[47:0] = samples.data.sample_time;
        for (int c = 0; c < NCHAN; c++)
        begin
            job_data[48 + c*SUM_W +: SUM_W] = sums_next[c];
        end
        job_data[48 + NCHAN*SUM_W +: CNT_W] = count_next;
        job_data[JOB_W-1] = average_enable;
    end

    assign wr_en   = accept && samples.data.read_ok;
    assign wr_addr = count_reg[ADDR_W-1:0];
    assign wr_row  = {samples.data.sample_time, ch[6], ch[5], ch[4], ch[3], ch[2], ch[1], ch[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NCHAN; c++)
            begin
                sums_reg[c] <= '0;
            end
            count_reg    <= '0;
            deadline_reg <= '0;
            armed_reg    <= 1'b0;
            wait_reg     <= 1'b0;
        end
        else
        begin
            wait_reg <= wait_next;
            if (accept)
            begin
                armed_reg    <= 1'b1;
                deadline_reg <= deadline_next;
                for (int c = 0; c < NCHAN; c++)
                begin
                    sums_reg[c] <= emit ? '0 : sums_next[c];
                end
                count_reg <= emit ? '0 : count_next;
            end
        end
    end

endmodule

// ===== hw/rtl/sba_queue.sv =====
// Two-entry job queue between the front end and the back end.
module sba_queue #(
    parameter int unsigned WIDTH = 209
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    logic [WIDTH-1:0] entry_reg [2];
    logic             wptr_reg, rptr_reg;
    logic [1:0]       fill_reg;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign pop_data = entry_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== hw/rtl/sba_back.sv =====
// Back end: sample memory, serial mean divider and result output register.
module sba_back #(
    parameter int unsigned MAX_BATCH = 64,
    parameter int unsigned CNT_W     = 7,
    parameter int unsigned ADDR_W    = 6,
    parameter int unsigned SUM_W     = 22,
    parameter int unsigned ROW_W     = 160,
    parameter int unsigned JOB_W     = 209
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ROW_W-1:0]  wr_row,
    input  logic [JOB_W-1:0]  job_data,
    input  logic              job_empty,
    output logic              job_pop,
    output logic              pass_done,
    sba_result_if.source      results
);
    import sba_pkg::*;

    localparam int unsigned STEP_W = $clog2(SUM_W);

    logic [ROW_W-1:0]        mem [MAX_BATCH];
    logic [ROW_W-1:0]        rd_row_reg;
    back_state_t             state_reg, state_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        k_reg, k_next;
    logic signed [SUM_W-1:0] sums_reg [NCHAN];
    logic signed [SUM_W-1:0] sums_next [NCHAN];
    logic [47:0]             time_reg, time_next;
    logic [2:0]              chan_reg, chan_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic [SUM_W-1:0]        quo_reg, quo_next;
    logic signed [15:0]      mean_reg [NCHAN];
    logic signed [15:0]      mean_next [NCHAN];
    result_t                 out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_free, load;
    logic [CNT_W:0]          trial;
    logic                    ge;
    logic [SUM_W-1:0]        quo_step, quo_signed;
    logic signed [SUM_W-1:0] next_sum;

    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;
    assign out_free      = !out_valid_reg || results.ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        rd_row_reg <= mem[k_reg[ADDR_W-1:0]];
    end

    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign ge       = trial >= {1'b0, n_reg};
    assign quo_step = {quo_reg[SUM_W-2:0], ge};
    assign next_sum = sums_reg[chan_reg + 3'd1];

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        sums_next      = sums_reg;
        time_next      = time_reg;
        chan_next      = chan_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        mean_next      = mean_reg;
        out_next       = out_reg;
        job_pop        = 1'b0;
        pass_done      = 1'b0;
        load           = 1'b0;
        quo_signed     = sums_reg[chan_reg][SUM_W-1] ? -quo_step : quo_step;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop   = 1'b1;
                    time_next = job_data[47:0];
                    for (int c = 0; c < NCHAN; c++)
                    begin
                        sums_next[c] = job_data[48 + c*SUM_W +: SUM_W];
                    end
                    n_next    = job_data[48 + NCHAN*SUM_W +: CNT_W];
                    k_next    = '0;
                    chan_next = 3'd0;
                    step_next = '0;
                    rem_next  = '0;
                    quo_next  = sums_next[0][SUM_W-1] ? -sums_next[0] : sums_next[0];
                    state_next = job_data[JOB_W-1] ? BK_DIV : BK_PASS_RD;
                end
            end
            BK_DIV:
            begin
                rem_next  = ge ? CNT_W'(trial - {1'b0, n_reg}) : trial[CNT_W-1:0];
                quo_next  = quo_step;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    mean_next[chan_reg] = quo_signed[15:0];
                    step_next = '0;
                    rem_next  = '0;
                    if (chan_reg == 3'(NCHAN - 1))
                    begin
                        state_next = BK_AVG_OUT;
                    end
                    else
                    begin
                        chan_next = chan_reg + 3'd1;
                        quo_next  = next_sum[SUM_W-1] ? -next_sum : next_sum;
                    end
                end
            end
            BK_AVG_OUT:
            begin
                if (out_free)
                begin
                    load                 = 1'b1;
                    out_next.out_accel_x = mean_reg[0];
                    out_next.out_accel_y = mean_reg[1];
                    out_next.out_accel_z = mean_reg[2];
                    out_next.out_temp    = mean_reg[3];
                    out_next.out_gyro_x  = mean_reg[4];
                    out_next.out_gyro_y  = mean_reg[5];
                    out_next.out_gyro_z  = mean_reg[6];
                    out_next.out_time    = time_reg;
                    out_next.batch_count = 7'(n_reg);
                    out_next.last        = 1'b1;
                    state_next           = BK_IDLE;
                end
            end
            BK_PASS_RD:
            begin
                state_next = BK_PASS_OUT;
            end
            BK_PASS_OUT:
            begin
                if (out_free)
                begin
                    load                 = 1'b1;
                    out_next.out_accel_x = rd_row_reg[15:0];
                    out_next.out_accel_y = rd_row_reg[31:16];
                    out_next.out_accel_z = rd_row_reg[47:32];
                    out_next.out_temp    = rd_row_reg[63:48];
                    out_next.out_gyro_x  = rd_row_reg[79:64];
                    out_next.out_gyro_y  = rd_row_reg[95:80];
                    out_next.out_gyro_z  = rd_row_reg[111:96];
                    out_next.out_time    = rd_row_reg[159:112];
                    out_next.batch_count = 7'(n_reg);
                    out_next.last        = (k_reg + CNT_W'(1) == n_reg);
                    if (out_next.last)
                    begin
                        pass_done  = 1'b1;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = BK_PASS_RD;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        out_valid_next = load || (out_valid_reg && !results.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        sums_reg <= sums_next;
        time_reg <= time_next;
        chan_reg <= chan_next;
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        mean_reg <= mean_next;
        out_reg  <= out_next;
    end

endmodule

// ===== verif/tb_sensor_batch_averager.sv =====
// Self-checking testbench of the sensor batch averager with a random sample and result flow.
`timescale 1ns / 100ps

module tb_sensor_batch_averager;
    import sba_pkg::*;

    localparam int unsigned MAX_BATCH  = 64;
    localparam int unsigned WATCH_MAX  = 20000;
    localparam int unsigned SETTLE_CYC = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    sba_sample_if s_ch();
    sba_result_if r_ch();

    sensor_batch_averager #(.MAX_BATCH(MAX_BATCH)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .samples(s_ch.sink),
        .results(r_ch.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Mirror of the block's registers and batch state.
    logic [15:0] m_interval = 16'd10;
    logic [6:0] m_batch = 7'd10;
    logic m_average = 1'b1;
    logic signed [15:0] m_samples [MAX_BATCH][NCHAN];
    logic [47:0] m_times [MAX_BATCH];
    int m_sums [NCHAN];
    int unsigned m_count = 0;
    logic [47:0] m_deadline = '0;
    logic m_armed = 1'b0;

    sample_t pending_samples[$];
    result_t expected_results[$];
    int unsigned mismatches = 0;
    bit gaps_on = 1'b1;
    bit hold_req = 1'b0;
    int unsigned hold_left = 0;
    logic [47:0] now_ms = '0;

    function automatic result_t make_result(logic signed [15:0] v [NCHAN], logic [47:0] t,
                                            int unsigned n, logic lst);
        result_t r;
        r.out_accel_x = v[0];
        r.out_accel_y = v[1];
        r.out_accel_z = v[2];
        r.out_temp    = v[3];
        r.out_gyro_x  = v[4];
        r.out_gyro_y  = v[5];
        r.out_gyro_z  = v[6];
        r.out_time    = t;
        r.batch_count = n[6:0];
        r.last        = lst;
        return r;
    endfunction

    task automatic predict_batch(sample_t s);
        int unsigned sz;
        int unsigned slot;
        int mean;
        logic signed [15:0] v [NCHAN];
        logic signed [15:0] mv [NCHAN];
        sz = (m_batch == 0) ? 1 : ((m_batch > MAX_BATCH) ? MAX_BATCH : m_batch);
        v = '{s.accel_x, s.accel_y, s.accel_z, s.temp_raw, s.gyro_x, s.gyro_y, s.gyro_z};
        if (!m_armed)
        begin
            m_deadline = s.sample_time;
            m_armed = 1'b1;
        end
        if (s.read_ok)
        begin
            slot = m_count % MAX_BATCH;
            for (int c = 0; c < NCHAN; c++)
            begin
                m_samples[slot][c] = v[c];
                m_sums[c] += v[c];
            end
            m_times[slot] = s.sample_time;
            if (m_count < MAX_BATCH)
                m_count++;
        end
        else
        begin
            m_count = 0;
            foreach (m_sums[c]) m_sums[c] = 0;
        end
        if (m_count >= sz || s.check_time > m_deadline)
        begin
            if (m_count > 0)
            begin
                if (m_average)
                begin
                    for (int c = 0; c < NCHAN; c++)
                    begin
                        mean = m_sums[c] / int'(m_count);
                        mv[c] = mean[15:0];
                    end
                    expected_results.push_back(make_result(mv, m_times[m_count - 1],
                                                           m_count, 1'b1));
                end
                else
                begin
                    for (int k = 0; k < m_count; k++)
                        expected_results.push_back(make_result(m_samples[k], m_times[k],
                                                               m_count, k + 1 == m_count));
                end
            end
            m_count = 0;
            foreach (m_sums[c]) m_sums[c] = 0;
            m_deadline = m_deadline + 48'(m_interval * sz);
        end
    endtask

    // Sender: offers queued samples with a random gap after each one while gaps_on is set.
    int unsigned gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_ch.valid <= 1'b0;
            s_ch.data <= '0;
            gap_left <= 0;
        end
        else if (!(s_ch.valid && !s_ch.ready))
        begin
            if (s_ch.valid)
                predict_batch(s_ch.data);
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_ch.valid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                s_ch.data <= pending_samples.pop_front();
                s_ch.valid <= 1'b1;
                gap_left <= gaps_on ? $urandom_range(0, 7) : 0;
            end
            else
                s_ch.valid <= 1'b0;
        end
    end

    // Receiver: checks each result transfer and stalls at random.
    int unsigned stall_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned next_stall;
        result_t exp_r;
        if (!rst_n)
        begin
            r_ch.ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            next_stall = stall_left;
            if (hold_req)
            begin
                hold_left = 400;
                hold_req = 1'b0;
            end
            if (r_ch.valid && r_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", r_ch.data);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== r_ch.data)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p, actual %p",
                                     exp_r, r_ch.data);
                    end
                end
                next_stall = gaps_on ? $urandom_range(0, 7) : 0;
            end
            else if (next_stall > 0)
                next_stall--;
            if (hold_left > 0)
                hold_left--;
            stall_left <= next_stall;
            r_ch.ready <= (next_stall == 0) && (hold_left == 0);
        end
    end

    // Watchdog on cycles without any transfer.
    int unsigned quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((s_ch.valid && s_ch.ready) || (r_ch.valid && r_ch.ready) || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCH_MAX)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic sample_t make_sample(bit ok, bit rand_vals, logic [15:0] fill,
                                            int unsigned step, int unsigned reach);
        sample_t s;
        logic [15:0] v [NCHAN];
        for (int c = 0; c < NCHAN; c++)
            v[c] = rand_vals ? 16'($urandom) : fill;
        s.accel_x = v[0];
        s.accel_y = v[1];
        s.accel_z = v[2];
        s.temp_raw = v[3];
        s.gyro_x = v[4];
        s.gyro_y = v[5];
        s.gyro_z = v[6];
        s.read_ok = ok;
        now_ms = now_ms + 48'($urandom_range(0, step));
        s.sample_time = now_ms;
        s.check_time = now_ms + 48'($urandom_range(0, reach));
        if ($urandom_range(0, 19) == 0)
            s.check_time = {16'($urandom), 32'($urandom)};
        return s;
    endfunction

    task automatic wait_idle();
        wait (pending_samples.size() == 0 && !s_ch.valid && expected_results.size() == 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_INTERVAL: m_interval = val;
            CFG_BATCH:    m_batch = val[6:0];
            default:      m_average = val[0];
        endcase
    endtask

    task automatic set_regs(logic [15:0] ivl, logic [6:0] bsz, logic avg);
        wait_idle();
        write_reg(CFG_INTERVAL, ivl);
        write_reg(CFG_BATCH, {9'd0, bsz});
        write_reg(CFG_AVERAGE, {15'd0, avg});
    endtask

    initial
    begin
        cfg_we <= 1'b0;
        cfg_index <= CFG_INTERVAL;
        cfg_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: extremes, failed reads, timeouts on an empty batch.
        set_regs(16'd1, 7'd3, 1'b1);
        pending_samples.push_back(make_sample(1, 0, 16'h7fff, 0, 0));
        pending_samples.push_back(make_sample(1, 0, 16'h7fff, 0, 0));
        pending_samples.push_back(make_sample(1, 0, 16'h7ffe, 0, 0));
        pending_samples.push_back(make_sample(1, 0, 16'h8000, 0, 0));
        pending_samples.push_back(make_sample(1, 0, 16'h8000, 0, 0));
        pending_samples.push_back(make_sample(1, 0, 16'hffff, 0, 0));
        pending_samples.push_back(make_sample(1, 0, 16'h0000, 1, 0));
        pending_samples.push_back(make_sample(0, 0, 16'h1234, 1, 0));
        pending_samples.push_back(make_sample(0, 0, 16'h0000, 2, 50));
        pending_samples.push_back(make_sample(1, 1, 16'h0000, 1, 0));
        pending_samples.push_back(make_sample(1, 1, 16'h0000, 1, 60));
        set_regs(16'd0, 7'd0, 1'b0);
        repeat (5) pending_samples.push_back(make_sample(1, 1, 16'h0000, 1, 2));
        set_regs(16'd65535, 7'd4, 1'b0);
        repeat (3) pending_samples.push_back(make_sample(1, 1, 16'h0000, 1, 0));
        set_regs(16'd65535, 7'd2, 1'b1);
        pending_samples.push_back(make_sample(1, 1, 16'h0000, 1, 0));

        // Largest batch, saturated from an oversized setting, with extreme codes.
        set_regs(16'd65535, 7'd127, 1'b1);
        for (int i = 0; i < 64; i++)
            pending_samples.push_back(make_sample(1, 0, (i % 8 == 7) ? 16'h7fff : 16'h8000,
                                                  1, 0));

        // Time wrap near the top of the 48-bit range.
        set_regs(16'd3, 7'd5, 1'b1);
        now_ms = 48'hffff_ffff_ffe0;
        m_deadline = m_deadline;
        repeat (12) pending_samples.push_back(make_sample(1, 1, 16'h0000, 8, 4));

        // Random phases, mostly small batches, with a long receiver hold-off in one.
        for (int p = 0; p < 4; p++)
        begin
            set_regs(16'($urandom_range(0, 20)),
                     (p == 2) ? 7'd1 : 7'($urandom_range(1, 8)),
                     1'($urandom_range(0, 1)));
            gaps_on = (p % 3 != 2);
            if (p == 2)
            begin
                @(negedge clk);
                hold_req = 1'b1;
            end
            repeat (16)
                pending_samples.push_back(make_sample($urandom_range(0, 9) != 0, 1, 16'h0000,
                                                      $urandom_range(0, 15),
                                                      ($urandom_range(0, 7) == 0) ? 200 : 3));
        end

        wait (pending_samples.size() == 0 && !s_ch.valid && expected_results.size() == 0);
        repeat (SETTLE_CYC) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
